@@ src/double_ended_queue_macros.svh @@
// Assertion helpers for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Checked only while out of reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned OccW   = 5;
  localparam int unsigned StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CmdPushBack  = 3'd0,
    CmdPushFront = 3'd1,
    CmdPopBack   = 3'd2,
    CmdPopFront  = 3'd3,
    CmdClear     = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StatDone      = 2'd0,
    StatPushFull  = 2'd1,
    StatPopEmpty  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [DataW-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] popped_value;
    logic [OccW-1:0]         occupancy;
    logic                    is_empty;
    logic [StatW-1:0]        status;
  } deq_out_t;

endpackage

`default_nettype wire

@@ src/double_ended_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Double-ended queue of signed 32-bit words, DEPTH entries, ring buffer.
// Input channel (in_valid_i / in_ready_o / in_data_i): one command per
//   transfer: push back, push front, pop back, pop front or clear.
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one
//   result per command: popped word (zero unless a pop succeeded),
//   occupancy after the command, empty flag and status.
// Result path: the transfer edge does the synchronous entry read into the read
//   stage, which loads the output register when it is free; the result is valid there.
// Throughput: one command per clock while the sink keeps taking results, set by
//   the single memory port (each command does at most one write or one read).
// Stall: a held output keeps its result; one more command may sit behind it
//   in the read stage, after which in_ready_o drops until the sink takes one.
// Reset: front index and count go to zero (empty queue), both pipeline
//   stages are emptied. Entry memory is not cleared; only written words are
//   ever read back. Clear works the same way: it just zeroes index and count.
// Undefined command codes leave the queue untouched and report done.
// Occupancy is reported on 5 bits.

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire deq_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output deq_out_t     out_data_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;

  // queue control state
  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;

  // read stage (waits for memory data)
  logic            s1_valid_q;
  logic            s1_pop_ok_q;
  logic [StatW-1:0] s1_status_q;
  logic [CntW-1:0] s1_count_q;

  // output register
  logic            out_valid_q;
  deq_out_t        out_q;

  // entry memory
  logic signed [DataW-1:0] mem_q [DEPTH];
  logic signed [DataW-1:0] rd_data_q;

  logic            in_fire;
  logic            s1_advance;
  logic            is_full, is_none;
  logic [SumW-1:0] back_sum, last_sum;
  logic [IdxW-1:0] back_idx, last_idx, front_inc, front_dec;
  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic            pop_ok;
  logic [StatW-1:0] status;

  // handshakes: read stage drains into the output register when it is free
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full = (count_q == CntW'(DEPTH));
  assign is_none = (count_q == '0);

  // back slot = front + count, last word = front + count - 1 (mod DEPTH)
  assign back_sum = SumW'(front_q) + SumW'(count_q);
  assign last_sum = back_sum - 1'b1;
  assign back_idx = (back_sum >= SumW'(DEPTH)) ? IdxW'(back_sum - SumW'(DEPTH))
                                               : IdxW'(back_sum);
  assign last_idx = (last_sum >= SumW'(DEPTH)) ? IdxW'(last_sum - SumW'(DEPTH))
                                               : IdxW'(last_sum);
  assign front_inc = (front_q == IdxW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - 1'b1;

  // command decode
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = back_idx;
    rd_addr = last_idx;
    pop_ok  = 1'b0;
    status  = StatDone;
    unique case (in_data_i.cmd)
      CmdPushBack: begin
        if (is_full) begin
          status = StatPushFull;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_idx;
          count_d = count_q + 1'b1;
        end
      end
      CmdPushFront: begin
        if (is_full) begin
          status = StatPushFull;
        end else begin
          wr_en   = 1'b1;
          wr_addr = front_dec;
          front_d = front_dec;
          count_d = count_q + 1'b1;
        end
      end
      CmdPopBack: begin
        if (is_none) begin
          status = StatPopEmpty;
        end else begin
          rd_en   = 1'b1;
          rd_addr = last_idx;
          pop_ok  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      CmdPopFront: begin
        if (is_none) begin
          status = StatPopEmpty;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front_q;
          pop_ok  = 1'b1;
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
      end
      CmdClear: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
        // unused codes: no-op
      end
    endcase
  end

  // entry memory: one write or one read per command
  always_ff @(posedge clk_i) begin
    if (in_fire && wr_en) begin
      mem_q[wr_addr] <= in_data_i.push_value;
    end
    if (in_fire && rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        front_q <= front_d;
        count_q <= count_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pop_ok_q <= pop_ok;
      s1_status_q <= status;
      s1_count_q  <= count_d;
    end
    if (s1_advance) begin
      out_q.popped_value <= s1_pop_ok_q ? rd_data_q : '0;
      out_q.occupancy    <= OccW'(s1_count_q);
      out_q.is_empty     <= (s1_count_q == '0);
      out_q.status       <= s1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ src/deq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire deq_out_t out_data_o
);

  `DEQ_ASSERT(a_empty_flag, out_valid_o |-> (out_data_o.is_empty == (out_data_o.occupancy == '0)), "empty flag disagrees with occupancy")
  `DEQ_ASSERT(a_occ_range, out_valid_o |-> (int'(out_data_o.occupancy) <= int'(DEPTH)), "occupancy above depth")
  `DEQ_ASSERT(a_pop_refused, (out_valid_o && out_data_o.status == StatPopEmpty) |-> (out_data_o.popped_value == '0 && out_data_o.occupancy == '0), "refused pop on a non-empty queue")
  `DEQ_ASSERT(a_push_refused, (out_valid_o && out_data_o.status == StatPushFull) |-> (out_data_o.popped_value == '0 && out_data_o.occupancy == OccW'(DEPTH)), "refused push on a non-full queue")
  `DEQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result shown right after reset")

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_data_o (out_data_o)
);

`default_nettype wire
